FILE: rtl/tlprt_pkg.sv
`default_nettype none

package tlprt_pkg;

    localparam int PAGE_BYTES   = 1024;
    localparam int REGION_COUNT = 4;
    localparam int SLOT_COUNT   = 64;
    localparam int BANK_PAGES   = 16384;
    localparam int WINDOW_BYTES = 16384;

    localparam int WINDOW_PAGES = (WINDOW_BYTES / PAGE_BYTES) > 0 ?
                                  (WINDOW_BYTES / PAGE_BYTES) : 1;
    localparam int PAGE_SH  = $clog2(PAGE_BYTES);
    localparam int PAGE_W   = $clog2(BANK_PAGES);
    localparam int REG_AW   = REGION_COUNT > 1 ? $clog2(REGION_COUNT) : 1;
    localparam int SLOT_AW  = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [1:0] {
        OP_PAGE_IN = 2'd0,
        OP_FLUSH   = 2'd1,
        OP_QUERY   = 2'd2,
        OP_BAD     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ACT_WRITE_BACK = 3'd0,
        ACT_COPY_OUT   = 3'd1,
        ACT_MAP        = 3'd2,
        ACT_UNMAP      = 3'd3,
        ACT_FILL_SLOT  = 3'd4,
        ACT_FILL_EXT   = 3'd5,
        ACT_QUERY_ANS  = 3'd6,
        ACT_OUT_RANGE  = 3'd7
    } t_action;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] address;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  action;
        logic [13:0] page;
        logic [5:0]  slot;
        logic [1:0]  region;
        logic [23:0] ext_address;
        logic        resident;
        logic        last;
    } t_res;

    function automatic logic [REG_AW-1:0] region_of(input logic [PAGE_W-1:0] page);
        return REG_AW'((page % WINDOW_PAGES) % REGION_COUNT);
    endfunction

    function automatic logic [SLOT_AW-1:0] slot_of(input logic [PAGE_W-1:0] page);
        return SLOT_AW'(page % SLOT_COUNT);
    endfunction

    function automatic logic [23:0] ext_of(input logic [PAGE_W-1:0] page);
        return 24'(32'(page) << PAGE_SH);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/two_level_page_residency_tracker.sv
// channel   ports                       handshake
// command   i_cmd (op, address)         start, taken when busy is low
// result    o_res (action ... last)     o_res_valid, one cycle, no stall
// config    i_cfg_we, i_cfg_wdata       base address written on i_cfg_we
//
// a small sequencer drives one subtractor, one page comparator and one
// slot-tag memory read port; the memory read is registered.
// query or out-of-range: subtract, check. page-in: subtract, check, then map
// and fill, evicting an occupant first. flush: evict, unmap each used region.
// reset (synchronous, active low) clears region and slot valid bits at once.
// results cannot be stalled; busy stays up until the last one, if any, issues.
`default_nettype none

module two_level_page_residency_tracker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire tlprt_pkg::t_cmd i_cmd,
    input  wire               i_cfg_we,
    input  wire  [31:0]       i_cfg_wdata,
    output logic              o_res_valid,
    output tlprt_pkg::t_res   o_res
);
    import tlprt_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SUB   = 9'b000000010,
        S_CHECK = 9'b000000100,
        S_SCAN  = 9'b000001000,
        S_EVWB  = 9'b000010000,
        S_EVCP  = 9'b000100000,
        S_UNMAP = 9'b001000000,
        S_MAP   = 9'b010000000,
        S_FILL  = 9'b100000000
    } t_state;

    t_state                 r_state, n_state;
    logic [31:0]            r_base_addr;
    logic [1:0]             r_op;
    logic [31:0]            r_addr;
    logic [PAGE_W-1:0]      r_page, n_page;
    logic                   r_ok, n_ok;
    logic [PAGE_W-1:0]      r_old, n_old;
    logic [REG_AW-1:0]      r_reg, n_reg;
    logic [REG_AW-1:0]      r_idx, n_idx;
    logic [REGION_COUNT-1:0] r_region_valid;
    logic [PAGE_W-1:0]      r_region_page [REGION_COUNT];
    logic [SLOT_COUNT-1:0]  r_slot_valid;
    logic [PAGE_W-1:0]      slot_mem [SLOT_COUNT];
    logic [PAGE_W-1:0]      r_slot_rdata;
    logic                   r_out_vld, n_out_vld;
    t_res                   r_out, n_out;

    logic [32:0]            diff;
    logic [REG_AW-1:0]      rsel;
    logic [PAGE_W-1:0]      rpg;
    logic [PAGE_W-1:0]      cmp_a;
    logic                   cmp_eq;
    logic [SLOT_AW-1:0]     s_old, s_new, raddr;
    logic                   later;
    logic                   rv_set, rv_clr, sv_set;

    // shared subtractor: address minus bank base, borrow in the top bit
    assign diff = {1'b0, r_addr} - {1'b0, r_base_addr};

    always_comb begin
        case (r_state)
            S_CHECK: rsel = region_of(r_page);
            S_SCAN:  rsel = r_idx;
            default: rsel = r_reg;
        endcase
    end

    assign rpg    = r_region_page[rsel];
    assign cmp_a  = (r_state == S_FILL) ? r_slot_rdata : rpg;
    assign cmp_eq = (cmp_a == r_page);
    assign s_old  = slot_of(r_old);
    assign s_new  = slot_of(r_page);
    assign raddr  = (r_state == S_MAP) ? s_new : slot_of(rpg);

    always_comb begin
        later = 1'b0;
        for (int k = 0; k < REGION_COUNT; k++) begin
            if (k > int'(r_idx) && r_region_valid[k]) begin
                later = 1'b1;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_page    = r_page;
        n_ok      = r_ok;
        n_old     = r_old;
        n_reg     = r_reg;
        n_idx     = r_idx;
        n_out_vld = 1'b0;
        n_out     = '0;
        rv_set    = 1'b0;
        rv_clr    = 1'b0;
        sv_set    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_idx   = '0;
                    n_state = (i_cmd.op == OP_FLUSH) ? S_SCAN : S_SUB;
                end
            end
            S_SUB: begin
                n_page  = diff[PAGE_SH +: PAGE_W];
                n_ok    = !diff[32] && ((diff[31:0] >> PAGE_SH) < 32'(BANK_PAGES));
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!r_ok || r_op == OP_BAD) begin
                    n_out_vld     = 1'b1;
                    n_out.action  = ACT_OUT_RANGE;
                    n_out.last    = 1'b1;
                    n_state       = S_IDLE;
                end else if (r_op == OP_QUERY) begin
                    n_out_vld      = 1'b1;
                    n_out.action   = ACT_QUERY_ANS;
                    n_out.page     = 14'(r_page);
                    n_out.region   = 2'(rsel);
                    n_out.resident = r_region_valid[rsel] && cmp_eq;
                    n_out.last     = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_reg = rsel;
                    n_old = rpg;
                    n_state = r_region_valid[rsel] ? S_EVWB : S_MAP;
                end
            end
            S_SCAN: begin
                if (r_region_valid[r_idx]) begin
                    n_reg   = r_idx;
                    n_old   = rpg;
                    n_state = S_EVWB;
                end else if (int'(r_idx) == REGION_COUNT - 1) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EVWB: begin
                // slot occupied: its page goes back to external memory first
                if (r_slot_valid[s_old]) begin
                    n_out_vld         = 1'b1;
                    n_out.action      = ACT_WRITE_BACK;
                    n_out.page        = 14'(r_slot_rdata);
                    n_out.slot        = 6'(s_old);
                    n_out.region      = 2'(r_reg);
                    n_out.ext_address = ext_of(r_slot_rdata);
                end
                n_state = S_EVCP;
            end
            S_EVCP: begin
                n_out_vld    = 1'b1;
                n_out.action = ACT_COPY_OUT;
                n_out.page   = 14'(r_old);
                n_out.slot   = 6'(s_old);
                n_out.region = 2'(r_reg);
                sv_set       = 1'b1;
                rv_clr       = 1'b1;
                n_state      = (r_op == OP_FLUSH) ? S_UNMAP : S_MAP;
            end
            S_UNMAP: begin
                n_out_vld    = 1'b1;
                n_out.action = ACT_UNMAP;
                n_out.page   = 14'(r_old);
                n_out.region = 2'(r_reg);
                n_out.last   = !later;
                if (later) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MAP: begin
                n_out_vld    = 1'b1;
                n_out.action = ACT_MAP;
                n_out.page   = 14'(r_page);
                n_out.region = 2'(r_reg);
                rv_set       = 1'b1;
                n_state      = S_FILL;
            end
            S_FILL: begin
                n_out_vld    = 1'b1;
                n_out.page   = 14'(r_page);
                n_out.slot   = 6'(s_new);
                n_out.region = 2'(r_reg);
                n_out.last   = 1'b1;
                if (r_slot_valid[s_new] && cmp_eq) begin
                    n_out.action = ACT_FILL_SLOT;
                end else begin
                    n_out.action      = ACT_FILL_EXT;
                    n_out.ext_address = ext_of(r_page);
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_base_addr    <= '0;
            r_region_valid <= '0;
            r_slot_valid   <= '0;
            r_out_vld      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_base_addr <= i_cfg_wdata;
            end
            if (rv_set) begin
                r_region_valid[r_reg] <= 1'b1;
            end else if (rv_clr) begin
                r_region_valid[r_reg] <= 1'b0;
            end
            if (sv_set) begin
                r_slot_valid[s_old] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op   <= i_cmd.op;
            r_addr <= i_cmd.address;
        end
        r_page <= n_page;
        r_ok   <= n_ok;
        r_old  <= n_old;
        r_reg  <= n_reg;
        r_idx  <= n_idx;
        r_out  <= n_out;
        if (rv_set) begin
            r_region_page[r_reg] <= r_page;
        end
    end

    // slot tag memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (sv_set) begin
            slot_mem[s_old] <= r_old;
        end
        r_slot_rdata <= slot_mem[raddr];
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

endmodule

`default_nettype wire

FILE: rtl/tlprt_checker.sv
`default_nettype none

module tlprt_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  start,
    input wire                  busy,
    input wire                  o_res_valid,
    input wire tlprt_pkg::t_res o_res
);
    import tlprt_pkg::*;

    // an accepted item keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted item");

    // more results of the run still to come
    a_run_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last) |-> busy)
        else $error("non-final result while idle");

    a_single_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.action == ACT_OUT_RANGE ||
                         o_res.action == ACT_QUERY_ANS)) |-> o_res.last)
        else $error("single-result item not marked last");

    a_resident_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.resident) |-> (o_res.action == ACT_QUERY_ANS))
        else $error("resident set on a non-query result");

endmodule

bind two_level_page_residency_tracker tlprt_checker u_tlprt_checker (.*);

`default_nettype wire
